// ----- src/mcp_pkg.sv -----
// Shared types and constants for the motion command text parser.
// Holds the parse phase enum, units codes, register indexes and character codes.
// No dependencies.
package mcp_pkg;

   typedef enum logic [2:0] {
      PH_IDLE  = 3'd0,
      PH_INDEX = 3'd1,
      PH_ID    = 3'd2,
      PH_WHOLE = 3'd3,
      PH_FRAC  = 3'd4,
      PH_UNITS = 3'd5,
      PH_DONE  = 3'd6
   } phase_type;

   typedef enum logic [1:0] {
      UNITS_NONE  = 2'd0,
      UNITS_DIST  = 2'd1,
      UNITS_SPEED = 2'd2
   } units_type;

   typedef enum logic [1:0] {
      REG_MAX_TURN    = 2'd0,
      REG_DEF_TURN    = 2'd1,
      REG_MAX_DIST    = 2'd2,
      REG_MAX_SPEED   = 2'd3
   } reg_index_type;

   localparam logic [7:0]  RST_MAX_TURN  = 8'd180;
   localparam logic [7:0]  RST_DEF_TURN  = 8'd90;
   localparam logic [15:0] RST_MAX_DIST  = 16'd10000;
   localparam logic [15:0] RST_MAX_SPEED = 16'd100;

   localparam logic [7:0] CASE_MASK = 8'hDF;
   localparam logic [7:0] CH_ZERO   = 8'h30;
   localparam logic [7:0] CH_NINE   = 8'h39;
   localparam logic [7:0] CH_HASH   = 8'h23;
   localparam logic [7:0] CH_DOT    = 8'h2E;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_NUL    = 8'h00;
   localparam logic [7:0] CH_F      = 8'h46;
   localparam logic [7:0] CH_B      = 8'h42;
   localparam logic [7:0] CH_R      = 8'h52;
   localparam logic [7:0] CH_L      = 8'h4C;
   localparam logic [7:0] CH_S      = 8'h53;
   localparam logic [7:0] CH_M      = 8'h4D;
   localparam logic [7:0] CH_H      = 8'h48;
   localparam logic [7:0] CH_D      = 8'h44;
   localparam logic [7:0] CH_V      = 8'h56;
   localparam logic [7:0] CH_P      = 8'h50;
   localparam logic [7:0] CH_E      = 8'h45;

   localparam logic [7:0] WHOLE_LIMIT = 8'd255;
   localparam logic [7:0] INDEX_LIMIT = 8'd99;

endpackage

// ----- src/motion_command_text_parser.sv -----
// Motion command text parser: top level with request register, parser and result register.
// Depends on mcp_pkg for the phase enum, units codes and character constants.
//
// A request marked last passes through the request register and then the result register.
// Throughput: one request per cycle unless stalled; the parser state updates once per request.
// A held result only stalls the request register when that register also holds a last.
// Reset (synchronous, active high) clears the parser, the valids and restores the limits.
module motion_command_text_parser (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_character,
   input  logic        req_last,
   // result channel
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_ok,
   output logic        rsp_index_given,
   output logic [6:0]  rsp_index,
   output logic [7:0]  rsp_command_id,
   output logic [1:0]  rsp_units_code,
   output logic [15:0] rsp_coded_value,
   // configuration port
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [3:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   // Limit registers.
   logic [7:0]  max_turn_ff;
   logic [7:0]  def_turn_ff;
   logic [15:0] max_dist_ff;
   logic [15:0] max_speed_ff;

   // Request register.
   logic        s1_valid_ff, s1_valid_in;
   logic [7:0]  s1_char_ff;
   logic        s1_last_ff;

   // Parser state.
   mcp_pkg::phase_type phase_ff, phase_in;
   mcp_pkg::units_type units_ff, units_in;
   logic [7:0]  whole_ff, whole_in;
   logic [6:0]  frac_ff, frac_in;
   logic [1:0]  frac_cnt_ff, frac_cnt_in;
   logic [7:0]  id_ff, id_in;
   logic [6:0]  index_ff, index_in;
   logic        index_seen_ff, index_seen_in;
   logic        error_ff, error_in;

   // Result register.
   logic        rsp_valid_ff, rsp_valid_in;
   logic        ok_ff, ok_in;
   logic        index_given_ff;
   logic [6:0]  index_out_ff;
   logic [7:0]  id_out_ff;
   logic [1:0]  units_out_ff;
   logic [15:0] coded_ff, coded_in;

   logic        advance;
   logic        csr_write;
   logic [7:0]  folded;
   logic [3:0]  digit;
   logic [11:0] whole_x10;
   logic [14:0] value;
   logic        letter_go;
   logic        letter_hit;

   // The request register moves on unless it holds a last whose result has nowhere to go.
   assign advance   = !(s1_valid_ff && s1_last_ff && rsp_valid_ff && !rsp_ready);
   assign req_ready = !s1_valid_ff || advance;
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;

   assign folded    = s1_char_ff & mcp_pkg::CASE_MASK;
   assign digit     = 4'(s1_char_ff - mcp_pkg::CH_ZERO);
   assign whole_x10 = 12'(whole_ff) * 12'd10 + 12'(digit);

   // A command letter is only taken before any letter has been seen, in the leading phases.
   assign letter_go = (phase_ff == mcp_pkg::PH_IDLE || phase_ff == mcp_pkg::PH_ID)
                      && (id_ff == 8'd0);

   always_ff @(posedge clock) begin
      if (reset) begin
         max_turn_ff  <= mcp_pkg::RST_MAX_TURN;
         def_turn_ff  <= mcp_pkg::RST_DEF_TURN;
         max_dist_ff  <= mcp_pkg::RST_MAX_DIST;
         max_speed_ff <= mcp_pkg::RST_MAX_SPEED;
      end else if (csr_write) begin
         case (mcp_pkg::reg_index_type'(paddr[3:2]))
            mcp_pkg::REG_MAX_TURN:  max_turn_ff  <= pwdata[7:0];
            mcp_pkg::REG_DEF_TURN:  def_turn_ff  <= pwdata[7:0];
            mcp_pkg::REG_MAX_DIST:  max_dist_ff  <= pwdata[15:0];
            mcp_pkg::REG_MAX_SPEED: max_speed_ff <= pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (mcp_pkg::reg_index_type'(paddr[3:2]))
         mcp_pkg::REG_MAX_TURN:  prdata = {24'd0, max_turn_ff};
         mcp_pkg::REG_DEF_TURN:  prdata = {24'd0, def_turn_ff};
         mcp_pkg::REG_MAX_DIST:  prdata = {16'd0, max_dist_ff};
         mcp_pkg::REG_MAX_SPEED: prdata = {16'd0, max_speed_ff};
         default:                prdata = 32'd0;
      endcase
   end

   // Request register.
   assign s1_valid_in = req_ready ? req_valid : s1_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         s1_char_ff <= req_character;
         s1_last_ff <= req_last;
      end
   end

   // Parser: feed the held character into the state, then on a last character
   // work out the result from the updated state and clear the parser.
   always_comb begin
      phase_in      = phase_ff;
      units_in      = units_ff;
      whole_in      = whole_ff;
      frac_in       = frac_ff;
      frac_cnt_in   = frac_cnt_ff;
      id_in         = id_ff;
      index_in      = index_ff;
      index_seen_in = index_seen_ff;
      error_in      = error_ff;
      letter_hit    = 1'b0;
      ok_in         = 1'b0;
      coded_in      = 16'd0;
      value         = 15'd0;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;

      if (!error_ff) begin
         if (s1_char_ff inside {[mcp_pkg::CH_ZERO:mcp_pkg::CH_NINE]}) begin
            if (phase_ff == mcp_pkg::PH_INDEX || phase_ff == mcp_pkg::PH_WHOLE) begin
               // The integer part saturates at its limit and flags an error there.
               if (whole_x10 >= 12'(mcp_pkg::WHOLE_LIMIT)) begin
                  error_in = 1'b1;
                  whole_in = mcp_pkg::WHOLE_LIMIT;
               end else begin
                  whole_in = whole_x10[7:0];
               end
            end else if (phase_ff == mcp_pkg::PH_FRAC) begin
               if (frac_cnt_ff == 2'd0) begin
                  frac_in = 7'(frac_ff + 7'(digit) * 7'd10);
               end else if (frac_cnt_ff == 2'd1) begin
                  frac_in = 7'(frac_ff + 7'(digit));
               end
               if (frac_cnt_ff != 2'd2) begin
                  frac_cnt_in = frac_cnt_ff + 2'd1;
               end
            end else begin
               error_in = 1'b1;
            end
         end else begin
            case (s1_char_ff)
               mcp_pkg::CH_HASH: begin
                  if (phase_ff == mcp_pkg::PH_IDLE) phase_in = mcp_pkg::PH_INDEX;
                  else error_in = 1'b1;
               end
               mcp_pkg::CH_DOT: begin
                  if (phase_ff == mcp_pkg::PH_WHOLE) phase_in = mcp_pkg::PH_FRAC;
                  else error_in = 1'b1;
               end
               mcp_pkg::CH_SPACE: begin
                  if (phase_ff == mcp_pkg::PH_INDEX) begin
                     if (whole_ff > mcp_pkg::INDEX_LIMIT) begin
                        error_in = 1'b1;
                     end else begin
                        index_in      = whole_ff[6:0];
                        index_seen_in = 1'b1;
                     end
                     whole_in = 8'd0;
                     phase_in = mcp_pkg::PH_ID;
                  end else if (phase_ff == mcp_pkg::PH_ID) begin
                     phase_in = mcp_pkg::PH_WHOLE;
                  end else if (phase_ff == mcp_pkg::PH_WHOLE ||
                               phase_ff == mcp_pkg::PH_FRAC) begin
                     phase_in = mcp_pkg::PH_UNITS;
                  end
               end
               mcp_pkg::CH_NUL: begin
                  phase_in = mcp_pkg::PH_DONE;
               end
               default: begin
                  case (folded)
                     mcp_pkg::CH_F, mcp_pkg::CH_B, mcp_pkg::CH_R, mcp_pkg::CH_L: begin
                        letter_hit = letter_go;
                        if (letter_go) phase_in = mcp_pkg::PH_ID;
                     end
                     mcp_pkg::CH_S: begin
                        if (phase_ff == mcp_pkg::PH_UNITS) units_in = mcp_pkg::UNITS_SPEED;
                        letter_hit = letter_go;
                        if (letter_go) phase_in = mcp_pkg::PH_DONE;
                     end
                     mcp_pkg::CH_M: begin
                        if (phase_ff == mcp_pkg::PH_UNITS &&
                            units_ff != mcp_pkg::UNITS_SPEED) begin
                           units_in = mcp_pkg::UNITS_DIST;
                        end
                        letter_hit = letter_go;
                        if (letter_go) phase_in = mcp_pkg::PH_DONE;
                     end
                     mcp_pkg::CH_H, mcp_pkg::CH_D, mcp_pkg::CH_V,
                     mcp_pkg::CH_P, mcp_pkg::CH_E: begin
                        letter_hit = letter_go;
                        if (letter_go) phase_in = mcp_pkg::PH_DONE;
                     end
                     default: ;
                  endcase
                  if (letter_hit) id_in = folded;
               end
            endcase
         end
      end

      // Final checks against the limits, on the state after this character.
      value = 15'(whole_in) * 15'd100 + 15'(frac_in);
      if (!error_in && id_in != 8'd0) begin
         ok_in = 1'b1;
         case (id_in)
            mcp_pkg::CH_R, mcp_pkg::CH_L: begin
               // The fraction is below one hundred, so whole degrees are the integer part.
               if (whole_in > max_turn_ff) begin
                  ok_in = 1'b0;
               end else if (whole_in == 8'd0) begin
                  coded_in = 16'(def_turn_ff);
               end else begin
                  coded_in = 16'(whole_in);
               end
            end
            mcp_pkg::CH_F, mcp_pkg::CH_B: begin
               coded_in = 16'(value);
               case (units_in)
                  mcp_pkg::UNITS_DIST:  ok_in = 16'(value) <= max_dist_ff;
                  mcp_pkg::UNITS_SPEED: ok_in = 16'(value) <= max_speed_ff;
                  default:              ok_in = 1'b0;
               endcase
            end
            mcp_pkg::CH_S, mcp_pkg::CH_H, mcp_pkg::CH_M,
            mcp_pkg::CH_D, mcp_pkg::CH_V, mcp_pkg::CH_P: begin
               if (value != 15'd0 || units_in != mcp_pkg::UNITS_NONE) ok_in = 1'b0;
            end
            default: ;
         endcase
      end
      if (!ok_in) coded_in = 16'd0;

      if (s1_valid_ff && s1_last_ff && advance) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= mcp_pkg::PH_IDLE;
         units_ff      <= mcp_pkg::UNITS_NONE;
         whole_ff      <= 8'd0;
         frac_ff       <= 7'd0;
         frac_cnt_ff   <= 2'd0;
         id_ff         <= 8'd0;
         index_ff      <= 7'd0;
         index_seen_ff <= 1'b0;
         error_ff      <= 1'b0;
      end else if (s1_valid_ff && advance) begin
         if (s1_last_ff) begin
            phase_ff      <= mcp_pkg::PH_IDLE;
            units_ff      <= mcp_pkg::UNITS_NONE;
            whole_ff      <= 8'd0;
            frac_ff       <= 7'd0;
            frac_cnt_ff   <= 2'd0;
            id_ff         <= 8'd0;
            index_ff      <= 7'd0;
            index_seen_ff <= 1'b0;
            error_ff      <= 1'b0;
         end else begin
            phase_ff      <= phase_in;
            units_ff      <= units_in;
            whole_ff      <= whole_in;
            frac_ff       <= frac_in;
            frac_cnt_ff   <= frac_cnt_in;
            id_ff         <= id_in;
            index_ff      <= index_in;
            index_seen_ff <= index_seen_in;
            error_ff      <= error_in;
         end
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_valid_ff && s1_last_ff && advance) begin
         ok_ff          <= ok_in;
         index_given_ff <= index_seen_in;
         index_out_ff   <= index_seen_in ? index_in : 7'd0;
         id_out_ff      <= id_in;
         units_out_ff   <= units_in;
         coded_ff       <= coded_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_ok          = ok_ff;
   assign rsp_index_given = index_given_ff;
   assign rsp_index       = index_out_ff;
   assign rsp_command_id  = id_out_ff;
   assign rsp_units_code  = units_out_ff;
   assign rsp_coded_value = coded_ff;

endmodule

// ----- tb/motion_command_text_parser_test.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the motion command text parser: directed commands, limit
// sweeps, random command text and a long result stall. Depends on mcp_pkg and the block.
module motion_command_text_parser_test;

   localparam int ITEM_TARGET    = 1250;  // characters to send before the run winds down
   localparam int HOLD_CYCLES    = 300;   // length of the long receiver stall
   localparam int WATCHDOG_LIMIT = 2000;  // cycles with no handshake before giving up
   localparam int PRINT_LIMIT    = 50;    // mismatches printed before going quiet

   typedef logic [7:0] char_queue_type[$];

   // One result as the block should present it.
   typedef struct packed {
      logic        ok;
      logic        index_given;
      logic [6:0]  index_number;
      logic [7:0]  command_id;
      logic [1:0]  units_code;
      logic [15:0] coded_value;
   } motion_result_type;

   logic        clock;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_character = '0;
   logic        req_last = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic        rsp_ok;
   logic        rsp_index_given;
   logic [6:0]  rsp_index;
   logic [7:0]  rsp_command_id;
   logic [1:0]  rsp_units_code;
   logic [15:0] rsp_coded_value;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [3:0]  paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic        pready;

   motion_command_text_parser dut (.*);

   // Shared run state. idle_on and hold_pending are changed with nonblocking
   // assignments so that the receiver always sees them from the next edge on.
   bit                idle_on = 1'b1;
   bit                hold_pending = 1'b0;
   int                mismatch_count = 0;
   int                chars_sent = 0;
   int                idle_cycles = 0;
   motion_result_type awaited_results[$];

   // The testbench's own copy of the parser state and of the limit registers.
   mcp_pkg::phase_type parse_phase;
   logic [7:0]         whole_part;
   logic [6:0]         frac_part;
   logic [1:0]         frac_count;
   logic [7:0]         held_id;
   mcp_pkg::units_type held_units;
   logic [6:0]         held_index;
   logic               index_seen;
   logic               error_seen;
   logic [15:0]        limit_regs[4];

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      if (mismatch_count < PRINT_LIMIT)
         $display("%0t mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
      mismatch_count++;
   endtask

   task automatic check_field(input string name, input logic [31:0] got,
                              input logic [31:0] want);
      if (got !== want)
         report_mismatch(name, got, want);
   endtask

   function automatic void clear_parse();
      parse_phase = mcp_pkg::PH_IDLE;
      whole_part  = '0;
      frac_part   = '0;
      frac_count  = '0;
      held_id     = '0;
      held_units  = mcp_pkg::UNITS_NONE;
      held_index  = '0;
      index_seen  = 1'b0;
      error_seen  = 1'b0;
   endfunction

   // A command letter only counts when no letter is held yet and the parser is
   // still before the value. Letters that take no value close the parse at once.
   function automatic void take_command_letter(input logic [7:0] c, input bit continues);
      if ((parse_phase == mcp_pkg::PH_IDLE || parse_phase == mcp_pkg::PH_ID) &&
          held_id == 8'h00) begin
         held_id = c & mcp_pkg::CASE_MASK;
         parse_phase = continues ? mcp_pkg::PH_ID : mcp_pkg::PH_DONE;
      end
   endfunction

   // Advances the parser by one accepted request. On the last character the
   // expected result is worked out and queued, and the parser starts over.
   function automatic void parse_character(input logic [7:0] c, input logic last);
      int                v;
      int                value;
      logic              ok;
      logic [15:0]       coded;
      motion_result_type r;
      if (!error_seen) begin
         if (c >= mcp_pkg::CH_ZERO && c <= mcp_pkg::CH_NINE) begin
            if (parse_phase == mcp_pkg::PH_INDEX || parse_phase == mcp_pkg::PH_WHOLE) begin
               // The integer part saturates at 255 and flags an error there.
               v = int'(whole_part) * 10 + int'(c - mcp_pkg::CH_ZERO);
               if (v >= int'(mcp_pkg::WHOLE_LIMIT)) begin
                  error_seen = 1'b1;
                  v = int'(mcp_pkg::WHOLE_LIMIT);
               end
               whole_part = 8'(v);
            end else if (parse_phase == mcp_pkg::PH_FRAC) begin
               if (frac_count == 2'd0)
                  frac_part = 7'(int'(frac_part) + 10 * int'(c - mcp_pkg::CH_ZERO));
               else if (frac_count == 2'd1)
                  frac_part = 7'(int'(frac_part) + int'(c - mcp_pkg::CH_ZERO));
               if (frac_count < 2'd2)
                  frac_count++;
            end else begin
               error_seen = 1'b1;
            end
         end else if (c == mcp_pkg::CH_HASH) begin
            if (parse_phase == mcp_pkg::PH_IDLE) parse_phase = mcp_pkg::PH_INDEX;
            else error_seen = 1'b1;
         end else if (c == mcp_pkg::CH_DOT) begin
            if (parse_phase == mcp_pkg::PH_WHOLE) parse_phase = mcp_pkg::PH_FRAC;
            else error_seen = 1'b1;
         end else if (c == mcp_pkg::CH_SPACE) begin
            if (parse_phase == mcp_pkg::PH_INDEX) begin
               if (whole_part > mcp_pkg::INDEX_LIMIT) begin
                  error_seen = 1'b1;
               end else begin
                  held_index = whole_part[6:0];
                  index_seen = 1'b1;
               end
               whole_part = '0;
               parse_phase = mcp_pkg::PH_ID;
            end else if (parse_phase == mcp_pkg::PH_ID) begin
               parse_phase = mcp_pkg::PH_WHOLE;
            end else if (parse_phase == mcp_pkg::PH_WHOLE ||
                         parse_phase == mcp_pkg::PH_FRAC) begin
               parse_phase = mcp_pkg::PH_UNITS;
            end
         end else if (c == mcp_pkg::CH_NUL) begin
            parse_phase = mcp_pkg::PH_DONE;
         end else begin
            case (c & mcp_pkg::CASE_MASK)
               mcp_pkg::CH_F, mcp_pkg::CH_B, mcp_pkg::CH_R, mcp_pkg::CH_L:
                  take_command_letter(c, 1'b1);
               mcp_pkg::CH_S: begin
                  if (parse_phase == mcp_pkg::PH_UNITS) held_units = mcp_pkg::UNITS_SPEED;
                  take_command_letter(c, 1'b0);
               end
               mcp_pkg::CH_M: begin
                  if (parse_phase == mcp_pkg::PH_UNITS && held_units != mcp_pkg::UNITS_SPEED)
                     held_units = mcp_pkg::UNITS_DIST;
                  take_command_letter(c, 1'b0);
               end
               mcp_pkg::CH_H, mcp_pkg::CH_D, mcp_pkg::CH_V, mcp_pkg::CH_P, mcp_pkg::CH_E:
                  take_command_letter(c, 1'b0);
               default: ;
            endcase
         end
      end
      if (last) begin
         ok = !error_seen && held_id != 8'h00;
         coded = '0;
         if (ok) begin
            value = int'(whole_part) * 100 + int'(frac_part);
            if (held_id == mcp_pkg::CH_R || held_id == mcp_pkg::CH_L) begin
               // Turns keep whole degrees; a zero turn takes the default unchecked.
               value = value / 100;
               if (value > int'(limit_regs[mcp_pkg::REG_MAX_TURN])) ok = 1'b0;
               else if (value == 0) value = int'(limit_regs[mcp_pkg::REG_DEF_TURN]);
               coded = 16'(value);
            end else if (held_id == mcp_pkg::CH_F || held_id == mcp_pkg::CH_B) begin
               if (held_units == mcp_pkg::UNITS_NONE)
                  ok = 1'b0;
               else if (held_units == mcp_pkg::UNITS_DIST)
                  ok = value <= int'(limit_regs[mcp_pkg::REG_MAX_DIST]);
               else
                  ok = value <= int'(limit_regs[mcp_pkg::REG_MAX_SPEED]);
               coded = 16'(value);
            end else if (held_id == mcp_pkg::CH_S || held_id == mcp_pkg::CH_H ||
                         held_id == mcp_pkg::CH_M || held_id == mcp_pkg::CH_D ||
                         held_id == mcp_pkg::CH_V || held_id == mcp_pkg::CH_P) begin
               if (value > 0 || held_units != mcp_pkg::UNITS_NONE) ok = 1'b0;
            end
         end
         r.ok           = ok;
         r.index_given  = index_seen;
         r.index_number = index_seen ? held_index : 7'd0;
         r.command_id   = held_id;
         r.units_code   = held_units;
         r.coded_value  = ok ? coded : 16'd0;
         awaited_results.push_back(r);
         clear_parse();
      end
   endfunction

   // Monitor: predicts on every accepted request, checks every accepted result
   // against the oldest expectation and keeps the watchdog going.
   always @(posedge clock) begin : monitor
      motion_result_type want;
      if (reset) begin
         clear_parse();
         limit_regs[mcp_pkg::REG_MAX_TURN]  = 16'(mcp_pkg::RST_MAX_TURN);
         limit_regs[mcp_pkg::REG_DEF_TURN]  = 16'(mcp_pkg::RST_DEF_TURN);
         limit_regs[mcp_pkg::REG_MAX_DIST]  = mcp_pkg::RST_MAX_DIST;
         limit_regs[mcp_pkg::REG_MAX_SPEED] = mcp_pkg::RST_MAX_SPEED;
         idle_cycles = 0;
      end else begin
         if (req_valid && req_ready)
            parse_character(req_character, req_last);
         if (rsp_valid && rsp_ready) begin
            if (awaited_results.size() == 0) begin
               report_mismatch("result with nothing expected", 32'd1, 32'd0);
            end else begin
               want = awaited_results.pop_front();
               check_field("ok", 32'(rsp_ok), 32'(want.ok));
               check_field("index_given", 32'(rsp_index_given), 32'(want.index_given));
               check_field("index", 32'(rsp_index), 32'(want.index_number));
               check_field("command_id", 32'(rsp_command_id), 32'(want.command_id));
               check_field("units_code", 32'(rsp_units_code), 32'(want.units_code));
               check_field("coded_value", 32'(rsp_coded_value), 32'(want.coded_value));
            end
         end
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t watchdog: no handshake for %0d cycles", $realtime, idle_cycles);
            $display("== FAIL ==");
            $finish;
         end
      end
   end

   // Receiver: before each result it may first hold ready low for a random stall. A hold request
   // from a test makes it drop ready for a long stretch so the block backs up.
   initial begin : receiver
      int stall;
      while (reset) @(posedge clock);
      forever begin
         if (hold_pending) begin
            rsp_ready <= 1'b0;
            hold_pending <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         stall = idle_on ? int'($urandom_range(0, 4)) : 0;
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid && !hold_pending) @(posedge clock);
      end
   end

   // Sends one character as a request. It is called at a clock edge and returns
   // at the edge where the request is taken. Valid is only lowered when a gap is
   // drawn, so back-to-back requests keep it high.
   task automatic send_char(input logic [7:0] c, input logic last);
      int gap;
      gap = idle_on ? int'($urandom_range(0, 4)) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_character <= c;
      req_last      <= last;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic send_command(input char_queue_type text);
      foreach (text[i])
         send_char(text[i], i == text.size() - 1);
      chars_sent += text.size();
   endtask

   function automatic void append_text(ref char_queue_type q, input string t);
      for (int i = 0; i < t.len(); i++)
         q.push_back(t[i]);
   endfunction

   task automatic send_text(input string t);
      char_queue_type q;
      append_text(q, t);
      send_command(q);
   endtask

   // Writes a value given in hundredths with 0 to 3 fraction digits; the third
   // fraction digit is random, since the block discards it.
   function automatic void append_value(ref char_queue_type q, input int v, input int digits);
      case (digits)
         0:       append_text(q, $sformatf("%0d", v / 100));
         1:       append_text(q, $sformatf("%0d.%0d", v / 100, (v % 100) / 10));
         2:       append_text(q, $sformatf("%0d.%02d", v / 100, v % 100));
         default: append_text(q, $sformatf("%0d.%02d%0d", v / 100, v % 100,
                                           $urandom_range(0, 9)));
      endcase
   endfunction

   // Mostly well-formed commands with random content, aimed at the current
   // limits now and then, plus some raw noise and some damaged commands.
   function automatic char_queue_type random_command();
      char_queue_type q;
      string          letters = "FBRLSHMDVPE";
      string          noise = "#. 0123456789FfBbRrLlMm/sSEx";
      logic [7:0]     c;
      int             v;
      int             n;
      if ($urandom_range(0, 9) == 0) begin
         n = $urandom_range(1, 8);
         repeat (n) begin
            if ($urandom_range(0, 1)) q.push_back(8'($urandom_range(0, 255)));
            else q.push_back(noise[$urandom_range(0, noise.len() - 1)]);
         end
         return q;
      end
      if ($urandom_range(0, 99) < 40) begin
         q.push_back(mcp_pkg::CH_HASH);
         v = ($urandom_range(0, 4) == 0) ? $urandom_range(100, 300) : $urandom_range(0, 99);
         append_text(q, $sformatf("%0d", v));
         if ($urandom_range(0, 9) != 0) q.push_back(mcp_pkg::CH_SPACE);
      end
      c = letters[$urandom_range(0, letters.len() - 1)];
      if ($urandom_range(0, 1)) c = c | 8'h20;
      q.push_back(c);
      case (c & mcp_pkg::CASE_MASK)
         mcp_pkg::CH_F, mcp_pkg::CH_B: begin
            q.push_back(mcp_pkg::CH_SPACE);
            case ($urandom_range(0, 3))
               0: v = $urandom_range(0, 999);
               1: v = $urandom_range(0, 30099);
               default: begin
                  // Land on or next to the distance or the speed limit, in hundredths.
                  v = $urandom_range(0, 1) ? int'(limit_regs[mcp_pkg::REG_MAX_DIST])
                                           : int'(limit_regs[mcp_pkg::REG_MAX_SPEED]);
                  v = v + int'($urandom_range(0, 2)) - 1;
                  if (v < 0) v = 0;
               end
            endcase
            append_value(q, v, $urandom_range(0, 3));
            case ($urandom_range(0, 6))
               0: ;
               1: append_text(q, " m");
               2: append_text(q, " M");
               3: append_text(q, " m/s");
               4: append_text(q, " M/S");
               5: append_text(q, " s");
               default: append_text(q, " m/s");
            endcase
         end
         mcp_pkg::CH_R, mcp_pkg::CH_L: begin
            if ($urandom_range(0, 5) != 0) begin
               q.push_back(mcp_pkg::CH_SPACE);
               case ($urandom_range(0, 2))
                  0: v = 0;
                  1: v = $urandom_range(0, 300);
                  default: v = int'(limit_regs[mcp_pkg::REG_MAX_TURN]) +
                               int'($urandom_range(0, 2)) - 1;
               endcase
               if (v < 0) v = 0;
               append_value(q, v * 100 + int'($urandom_range(0, 99)), $urandom_range(0, 3));
            end
         end
         mcp_pkg::CH_E: ;
         default: begin
            if ($urandom_range(0, 3) == 0) begin
               q.push_back(mcp_pkg::CH_SPACE);
               append_value(q, int'($urandom_range(0, 1)) * int'($urandom_range(0, 150)),
                            $urandom_range(0, 2));
               if ($urandom_range(0, 2) == 0) append_text(q, " m");
            end
         end
      endcase
      if ($urandom_range(0, 14) == 0)
         q.insert($urandom_range(0, q.size()), 8'($urandom_range(0, 255)));
      if ($urandom_range(0, 19) == 0)
         q.push_back(mcp_pkg::CH_NUL);
      return q;
   endfunction

   // Drops valid and waits until every expected result has come back, then waits
   // settle more cycles for anything still moving through the block. The first
   // edge lets the monitor queue the result of the request just taken.
   task automatic drain_results(input int settle);
      req_valid <= 1'b0;
      @(posedge clock);
      while (awaited_results.size() != 0) @(posedge clock);
      repeat (settle) @(posedge clock);
   endtask

   // Reads all four limit registers back and compares with the local copy.
   // Accesses run back to back, so psel only drops after the last one.
   task automatic check_limit_readback();
      for (int i = 0; i < 4; i++) begin
         psel    <= 1'b1;
         penable <= 1'b0;
         pwrite  <= 1'b0;
         paddr   <= {mcp_pkg::reg_index_type'(i), 2'b00};
         @(posedge clock);
         penable <= 1'b1;
         @(posedge clock);
         while (!pready) @(posedge clock);
         check_field($sformatf("limit register %0d readback", i), prdata,
                     {16'h0000, limit_regs[i]});
      end
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   // Writes all four limits while the parser is quiet, then reads them back.
   task automatic apply_limits(input logic [7:0] turn_max, input logic [7:0] turn_default,
                               input logic [15:0] dist_max, input logic [15:0] speed_max);
      logic [15:0] vals[4];
      vals[mcp_pkg::REG_MAX_TURN]  = {8'h00, turn_max};
      vals[mcp_pkg::REG_DEF_TURN]  = {8'h00, turn_default};
      vals[mcp_pkg::REG_MAX_DIST]  = dist_max;
      vals[mcp_pkg::REG_MAX_SPEED] = speed_max;
      drain_results(4);
      for (int i = 0; i < 4; i++) begin
         psel    <= 1'b1;
         penable <= 1'b0;
         pwrite  <= 1'b1;
         paddr   <= {mcp_pkg::reg_index_type'(i), 2'b00};
         pwdata  <= {16'h0000, vals[i]};
         @(posedge clock);
         penable <= 1'b1;
         @(posedge clock);
         while (!pready) @(posedge clock);
         limit_regs[i] = vals[i];
      end
      check_limit_readback();
   endtask

   // Limits straight out of reset, probed right at their edges.
   task automatic test_reset_limits();
      check_limit_readback();
      send_text("R 0");
      send_text("l 180");
      send_text("R 181");
      send_text("F 100 m");
      send_text("b 100.01 m");
      send_text("F 1 m/s");
      send_text("F 1.01 M/S");
      send_text("F 5");
   endtask

   // The parser's corner cases, one short command each.
   task automatic test_special_cases();
      char_queue_type q;
      send_text("#99 E");
      send_text("#100 E");
      send_text("#12");
      send_text("F 1.239 m");
      send_text("F 2.x5 m");
      send_text("F 255 m");
      send_text("9F 1 m");
      send_text("F.5 m");
      send_text("F 1 m 7");
      send_text("FB 1 m");
      send_text("Q");
      send_text("S 1");
      send_text("hmdvps");
      q = {mcp_pkg::CH_E, mcp_pkg::CH_NUL};
      send_command(q);
      q = {mcp_pkg::CH_R, mcp_pkg::CH_NUL, mcp_pkg::CH_SPACE, mcp_pkg::CH_ZERO + 8'd5};
      send_command(q);
      q = {8'hFF};
      send_command(q);
      q = {mcp_pkg::CH_NUL};
      send_command(q);
   endtask

   // Extreme and odd limit settings, each followed by random commands.
   task automatic test_limit_sweep();
      apply_limits(8'd0, 8'd0, 16'd0, 16'd0);
      repeat (20) send_command(random_command());
      apply_limits(8'd255, 8'd255, 16'hFFFF, 16'hFFFF);
      repeat (20) send_command(random_command());
      idle_on <= 1'b0;
      apply_limits(8'd1, 8'd200, 16'd1, 16'd25499);
      repeat (20) send_command(random_command());
      idle_on <= 1'b1;
      apply_limits(mcp_pkg::RST_MAX_TURN, mcp_pkg::RST_DEF_TURN, mcp_pkg::RST_MAX_DIST,
                   mcp_pkg::RST_MAX_SPEED);
      repeat (20) send_command(random_command());
   endtask

   // Bulk random traffic, with fresh limits and idling on or off for each batch.
   task automatic test_random_traffic();
      logic [15:0] dist_max;
      logic [15:0] speed_max;
      while (chars_sent < ITEM_TARGET) begin
         dist_max  = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 65535))
                                                 : 16'($urandom_range(0, 26000));
         speed_max = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 65535))
                                                 : 16'($urandom_range(0, 26000));
         apply_limits(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                      dist_max, speed_max);
         idle_on <= ($urandom_range(0, 3) != 0);
         repeat (25) send_command(random_command());
      end
   endtask

   // The receiver stalls for a long stretch while the sender keeps offering
   // short commands, so results pile up and the block must stop taking requests.
   task automatic test_stalled_receiver();
      drain_results(4);
      idle_on      <= 1'b0;
      hold_pending <= 1'b1;
      repeat (40) begin
         if ($urandom_range(0, 1)) send_text("E");
         else send_text("#3 r 45");
      end
      idle_on <= 1'b1;
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_limits();
      test_special_cases();
      test_limit_sweep();
      test_stalled_receiver();
      test_random_traffic();
      drain_results(16);
      if (mismatch_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

// ----- files.f -----
src/mcp_pkg.sv
src/motion_command_text_parser.sv
tb/motion_command_text_parser_test.sv
